/* rtl/core/ils_pkg.sv */
// ils_pkg: types and constants for the indexed list store
// operation and status codes, field widths, and the control word that feeds the cell row
// no dependencies
`timescale 1ns / 1ps

package ils_pkg;

  localparam int KIND_W = 3;
  localparam int POS_W  = 8;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 8;

  localparam logic [DATA_W-1:0] READ_MISS = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ = 3'd0,
    KIND_HEAD = 3'd1,
    KIND_TAIL = 3'd2,
    KIND_AT   = 3'd3,
    KIND_DEL  = 3'd4
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic              ins;
    logic              del;
    logic [POS_W-1:0]  where;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

/* rtl/core/ils_req_if.sv */
// ils_req_if: request channel of the indexed list store
// valid/ready handshake with kind, position and item value; uses ils_pkg widths
`timescale 1ns / 1ps

interface ils_req_if import ils_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [POS_W-1:0]    position;
  logic signed [DATA_W-1:0] item_value;

  modport source (output valid, output kind, output position, output item_value,
                  input ready);
  modport sink   (input valid, input kind, input position, input item_value,
                  output ready);

endinterface

/* rtl/core/ils_rsp_if.sv */
// ils_rsp_if: response channel of the indexed list store
// valid/ready handshake with status, read value and list length; uses ils_pkg widths
`timescale 1ns / 1ps

interface ils_rsp_if import ils_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] read_value;
  logic [CNT_W-1:0]         list_length;

  modport source (output valid, output status, output read_value, output list_length,
                  input ready);
  modport sink   (input valid, input status, input read_value, input list_length,
                  output ready);

endinterface

/* rtl/core/indexed_list_store.sv */
// indexed_list_store: bounded ordered list of signed 32-bit values
// top level; instantiates a row of ils_cell, uses ils_pkg, ils_req_if and ils_rsp_if
`timescale 1ns / 1ps

// Usage
//   req: one request per handshake: kind (read, insert head, insert tail,
//        insert at position, delete at position), position and item_value.
//   rsp: exactly one response per request, in order: status (done, out of
//        range, full), read_value (entry for a good read, else all ones) and
//        list_length after the request.
// Timing
//   The response is valid the cycle after the request is taken. One request
//   per cycle is sustained while rsp.ready is high: every cell compares its
//   own position with the requested one and shifts in the same cycle, and a
//   read picks one cell through a select over the row.
// Reset
//   rst clears the entry count and the response valid; entry contents are
//   not cleared, and a slot is only read once a value has been written there.
// Stall
//   While a response is held because rsp.ready is low, req.ready is low and
//   the list does not change. The response register frees up as it is taken,
//   so a new request can enter in the same cycle.

module indexed_list_store import ils_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic     clk,
  input  logic     rst,
  ils_req_if.sink  req,
  ils_rsp_if.source rsp
);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              rsp_valid;
  logic [STAT_W-1:0] rsp_status;
  logic [DATA_W-1:0] rsp_data;
  logic [CNT_W-1:0]  rsp_len;

  logic              accept;
  kind_t             op;
  logic [POS_W-1:0]  where;
  logic              ins_ok;
  logic              del_ok;
  status_t           st;
  logic [DATA_W-1:0] rd;
  logic [DATA_W-1:0] rd_any;
  logic              full;
  cell_ctrl_t        ctrl;

  logic [DATA_W-1:0] entry [CAPACITY];
  logic [DATA_W-1:0] sel   [CAPACITY];

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign op        = kind_t'(req.kind);
  assign full      = (count >= CNT_W'(CAPACITY));

  always_comb begin
    case (op)
      KIND_HEAD: where = '0;
      KIND_TAIL: where = POS_W'(count);
      default:   where = req.position;
    endcase
  end

  always_comb begin
    st         = ST_RANGE;
    rd         = READ_MISS;
    ins_ok     = 1'b0;
    del_ok     = 1'b0;
    count_next = count;
    case (op)
      KIND_READ: begin
        if (CNT_W'(req.position) < count) begin
          st = ST_DONE;
          rd = rd_any;
        end
      end
      KIND_HEAD, KIND_TAIL, KIND_AT: begin
        if (CNT_W'(where) > count) begin
          st = ST_RANGE;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          st         = ST_DONE;
          ins_ok     = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      KIND_DEL: begin
        if (CNT_W'(req.position) < count) begin
          st         = ST_DONE;
          del_ok     = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      default: st = ST_RANGE;
    endcase
  end

  assign ctrl.ins   = accept && ins_ok;
  assign ctrl.del   = accept && del_ok;
  assign ctrl.where = where;
  assign ctrl.value = req.item_value;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left;
      logic [DATA_W-1:0] right;
      if (i == 0) begin : g_first
        assign left = req.item_value;
      end else begin : g_mid_l
        assign left = entry[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right = entry[i];
      end else begin : g_mid_r
        assign right = entry[i+1];
      end
      ils_cell #(
        .IDX (i)
      ) u_cell (
        .clk   (clk),
        .ctrl  (ctrl),
        .left  (left),
        .right (right),
        .entry (entry[i]),
        .sel   (sel[i])
      );
    end
  endgenerate

  always_comb begin
    rd_any = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_any = rd_any | sel[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status <= st;
      rsp_data   <= rd;
      rsp_len    <= count_next;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.read_value  = rsp_data;
  assign rsp.list_length = rsp_len;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid)
    else $error("request taken without a response");

  a_len_tracks: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.list_length == count)
    else $error("response length differs from entry count");

  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_DONE) |-> rsp.read_value == READ_MISS)
    else $error("failed request carries a read value");
`endif

endmodule

/* rtl/core/ils_cell.sv */
// ils_cell: one list slot, holds the entry at a fixed position
// shifts from its left neighbor on insert and from its right neighbor on delete; uses ils_pkg
`timescale 1ns / 1ps

module ils_cell import ils_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [DATA_W-1:0] left,
  input  logic [DATA_W-1:0] right,
  output logic [DATA_W-1:0] entry,
  output logic [DATA_W-1:0] sel
);

  logic at_pos;
  logic past_pos;

  assign at_pos   = (ctrl.where == POS_W'(IDX));
  assign past_pos = (ctrl.where <= POS_W'(IDX));

  always_ff @(posedge clk) begin
    if (ctrl.ins && past_pos) begin
      entry <= at_pos ? ctrl.value : left;
    end else if (ctrl.del && past_pos) begin
      entry <= right;
    end
  end

  // masked entry for the row-wide read select
  assign sel = at_pos ? entry : '0;

endmodule
